### rtl/mm_pkg.sv
`timescale 1ns / 1ps

package mm_pkg;

  localparam int MAX_DIM = 8;
  localparam int ELEM_W  = 16;
  localparam int DIM_W   = 4;
  localparam int IDX_W   = 3;
  localparam int ADDR_W  = 6;
  localparam int CNT_W   = 7;
  localparam int TOT_W   = 8;
  localparam int PROD_W  = 32;
  localparam int ACC_W   = 35;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic [DIM_W-1:0]         dim_t;
  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  typedef enum logic [1:0] {
    CFG_A_ROWS = 2'd0,
    CFG_A_COLS = 2'd1,
    CFG_B_ROWS = 2'd2,
    CFG_B_COLS = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic  a_we;
    logic  b_we;
    addr_t addr;
    elem_t data;
  } store_wr_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctrl_t;

  // zero acts as one, anything above MAX_DIM saturates
  function automatic dim_t eff_dim(input dim_t v);
    dim_t r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

### rtl/mm_if.sv
`timescale 1ns / 1ps

interface mm_elem_if;
  import mm_pkg::*;

  logic  valid;
  logic  ready;
  elem_t element_value;

  modport source (output valid, output element_value, input ready);
  modport sink (input valid, input element_value, output ready);
endinterface

interface mm_result_if;
  import mm_pkg::*;

  logic valid;
  logic ready;
  acc_t product_value;
  idx_t out_row;
  idx_t out_col;
  logic size_error;
  logic last;

  modport source (output valid, output product_value, output out_row, output out_col,
                  output size_error, output last, input ready);
  modport sink (input valid, input product_value, input out_row, input out_col,
                input size_error, input last, output ready);
endinterface

### rtl/matrix_multiply.sv
`timescale 1ns / 1ps

// Multiplies A (a_rows x a_cols) by B (b_rows x b_cols), signed Q8.8 elements in,
// exact signed Q19.16 sums out. While ready is high elements enter one per cycle, A then
// B, both row-major; the item that completes B starts the product, which leaves row-major
// with row and column tags and last on the final result. If a_cols differs from b_rows a
// single result with size_error set and zero payload is sent instead. Dimensions of 0 act
// as 1 and above 8 as 8. Once loaded, the block drops ready and computes every result on
// one shared multiply-accumulate unit, one term per cycle; each sum passes the store read,
// the product register and the accumulator before it is offered on the output.
// The user must write configuration only while no run is producing results; the block
// does not enforce this.

module matrix_multiply (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  mm_pkg::cfg_reg_e cfg_idx_i,
  input  mm_pkg::dim_t     cfg_data_i,
  mm_elem_if.sink          elem_i,
  mm_result_if.source      result_o
);
  import mm_pkg::*;

  typedef enum logic [4:0] {
    ST_LOAD = 5'b00001,
    ST_CALC = 5'b00010,
    ST_WAIT = 5'b00100,
    ST_EMIT = 5'b01000,
    ST_ERR  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  dim_t a_rows_q, a_cols_q, b_rows_q, b_cols_q;
  dim_t ar, ac, br, bc;

  logic [CNT_W-1:0] lc_q, lc_d, lc_inc;
  logic [TOT_W-1:0] na, nb, total, bi;
  logic             in_a, run_end, size_err;

  idx_t r_q, r_d, c_q, c_d, k_q, k_d;
  logic k_last, c_end, r_end;

  logic [ADDR_W:0] a_idx, b_idx;

  store_wr_t wr;
  mac_ctrl_t ctrl;
  elem_t     a_data, b_data;
  acc_t      acc;
  logic      mac_done;

  logic out_valid_q, out_valid_d, out_free, out_load;
  acc_t out_val_q, out_val_d;
  idx_t out_row_q, out_row_d, out_col_q, out_col_d;
  logic out_err_q, out_err_d, out_last_q, out_last_d;

  logic accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_rows_q <= DIM_W'(1);
      a_cols_q <= DIM_W'(1);
      b_rows_q <= DIM_W'(1);
      b_cols_q <= DIM_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_A_ROWS: a_rows_q <= cfg_data_i;
        CFG_A_COLS: a_cols_q <= cfg_data_i;
        CFG_B_ROWS: b_rows_q <= cfg_data_i;
        CFG_B_COLS: b_cols_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign ar = eff_dim(a_rows_q);
  assign ac = eff_dim(a_cols_q);
  assign br = eff_dim(b_rows_q);
  assign bc = eff_dim(b_cols_q);

  assign na       = TOT_W'(ar) * TOT_W'(ac);
  assign nb       = TOT_W'(br) * TOT_W'(bc);
  assign total    = na + nb;
  assign size_err = (ac != br);

  assign accept  = elem_i.valid && elem_i.ready;
  assign lc_inc  = lc_q + CNT_W'(1);
  assign in_a    = TOT_W'(lc_q) < na;
  assign bi      = TOT_W'(lc_q) - na;
  assign run_end = (lc_inc == '0) || (TOT_W'(lc_inc) >= total);

  always_comb begin
    wr.data = elem_i.element_value;
    wr.addr = in_a ? lc_q[ADDR_W-1:0] : bi[ADDR_W-1:0];
    wr.a_we = accept && in_a;
    wr.b_we = accept && !in_a && (bi[TOT_W-1:ADDR_W] == '0);
  end

  assign a_idx = (ADDR_W+1)'(r_q) * (ADDR_W+1)'(ac) + (ADDR_W+1)'(k_q);
  assign b_idx = (ADDR_W+1)'(k_q) * (ADDR_W+1)'(bc) + (ADDR_W+1)'(c_q);

  assign k_last = DIM_W'(k_q) == ac - DIM_W'(1);
  assign c_end  = DIM_W'(c_q) == bc - DIM_W'(1);
  assign r_end  = DIM_W'(r_q) == ar - DIM_W'(1);

  assign out_free = !out_valid_q || result_o.ready;

  always_comb begin
    state_d    = state_q;
    lc_d       = lc_q;
    r_d        = r_q;
    c_d        = c_q;
    k_d        = k_q;
    ctrl       = '0;
    out_load   = 1'b0;
    out_val_d  = acc;
    out_row_d  = r_q;
    out_col_d  = c_q;
    out_err_d  = 1'b0;
    out_last_d = r_end && c_end;
    case (state_q)
      ST_LOAD: begin
        if (accept) begin
          lc_d = lc_inc;
          if (run_end) begin
            lc_d    = '0;
            r_d     = '0;
            c_d     = '0;
            k_d     = '0;
            state_d = size_err ? ST_ERR : ST_CALC;
          end
        end
      end
      ST_CALC: begin
        ctrl.valid = 1'b1;
        ctrl.first = (k_q == '0);
        ctrl.last  = k_last;
        if (k_last) begin
          k_d     = '0;
          state_d = ST_WAIT;
        end else begin
          k_d = k_q + IDX_W'(1);
        end
      end
      ST_WAIT: begin
        if (mac_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (r_end && c_end) begin
            state_d = ST_LOAD;
          end else begin
            state_d = ST_CALC;
            if (c_end) begin
              c_d = '0;
              r_d = r_q + IDX_W'(1);
            end else begin
              c_d = c_q + IDX_W'(1);
            end
          end
        end
      end
      ST_ERR: begin
        out_val_d  = '0;
        out_row_d  = '0;
        out_col_d  = '0;
        out_err_d  = 1'b1;
        out_last_d = 1'b1;
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      lc_q        <= '0;
      r_q         <= '0;
      c_q         <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lc_q        <= lc_d;
      r_q         <= r_d;
      c_q         <= c_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_val_q  <= out_val_d;
      out_row_q  <= out_row_d;
      out_col_q  <= out_col_d;
      out_err_q  <= out_err_d;
      out_last_q <= out_last_d;
    end
  end

  mm_store u_store (
    .clk_i    (clk_i),
    .wr_i     (wr),
    .a_raddr_i(a_idx[ADDR_W-1:0]),
    .b_raddr_i(b_idx[ADDR_W-1:0]),
    .a_data_o (a_data),
    .b_data_o (b_data)
  );

  mm_mac u_mac (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(ctrl),
    .a_i   (a_data),
    .b_i   (b_data),
    .acc_o (acc),
    .done_o(mac_done)
  );

  assign elem_i.ready           = (state_q == ST_LOAD);
  assign result_o.valid         = out_valid_q;
  assign result_o.product_value = out_val_q;
  assign result_o.out_row       = out_row_q;
  assign result_o.out_col       = out_col_q;
  assign result_o.size_error    = out_err_q;
  assign result_o.last          = out_last_q;

  a_count_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_LOAD) |-> (lc_q == '0))
    else $error("load count not cleared during compute");

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_done |-> (state_q == ST_WAIT))
    else $error("mac finished outside of wait");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_err_q) |-> (out_val_q == '0 && out_last_q))
    else $error("size error item with nonzero payload");

endmodule

### rtl/mm_store.sv
`timescale 1ns / 1ps

module mm_store (
  input  logic              clk_i,
  input  mm_pkg::store_wr_t wr_i,
  input  mm_pkg::addr_t     a_raddr_i,
  input  mm_pkg::addr_t     b_raddr_i,
  output mm_pkg::elem_t     a_data_o,
  output mm_pkg::elem_t     b_data_o
);
  import mm_pkg::*;

  localparam int Depth = 1 << ADDR_W;

  elem_t a_mem [Depth];
  elem_t b_mem [Depth];
  elem_t a_rd_q;
  elem_t b_rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.a_we) begin
      a_mem[wr_i.addr] <= wr_i.data;
    end
    a_rd_q <= a_mem[a_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.b_we) begin
      b_mem[wr_i.addr] <= wr_i.data;
    end
    b_rd_q <= b_mem[b_raddr_i];
  end

  assign a_data_o = a_rd_q;
  assign b_data_o = b_rd_q;

endmodule

### rtl/mm_mac.sv
`timescale 1ns / 1ps

module mm_mac (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mm_pkg::mac_ctrl_t ctrl_i,
  input  mm_pkg::elem_t     a_i,
  input  mm_pkg::elem_t     b_i,
  output mm_pkg::acc_t      acc_o,
  output logic              done_o
);
  import mm_pkg::*;

  mac_ctrl_t                s1_q;
  mac_ctrl_t                s2_q;
  logic                     done_q;
  logic signed [PROD_W-1:0] prod_q;
  acc_t                     acc_q;
  acc_t                     acc_d;

  // tags follow the store read latency, then the product register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q   <= '0;
      s2_q   <= '0;
      done_q <= 1'b0;
    end else begin
      s1_q   <= ctrl_i;
      s2_q   <= s1_q;
      done_q <= s2_q.valid && s2_q.last;
    end
  end

  always_comb begin
    acc_d = (s2_q.first ? acc_t'(0) : acc_q) + ACC_W'(prod_q);
  end

  always_ff @(posedge clk_i) begin
    if (s1_q.valid) begin
      prod_q <= PROD_W'(a_i) * PROD_W'(b_i);
    end
    if (s2_q.valid) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o  = acc_q;
  assign done_o = done_q;

  a_done_follows_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(s2_q.valid && s2_q.last))
    else $error("mac done without a last term");

  a_s2_follows_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_q.valid |-> $past(s1_q.valid))
    else $error("mac stage 2 valid without stage 1");

  a_first_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_q.valid && s2_q.first) |=> acc_q == ACC_W'($past(prod_q)))
    else $error("first term did not restart the sum");

endmodule

### tb/sv/matrix_multiply_tb.sv
`timescale 1ns / 1ps

module matrix_multiply_tb;
  import mm_pkg::*;

  localparam int QUIET_LIMIT  = 4000;
  localparam int RANDOM_ITEMS = 460;
  localparam int HOLD_CYCLES  = 400;
  localparam int STORE_SIZE   = MAX_DIM * MAX_DIM;

  typedef struct packed {
    acc_t value;
    idx_t row;
    idx_t col;
    logic err;
    logic last;
  } product_t;

  typedef struct packed {
    logic     set_dims;
    dim_t     ar;
    dim_t     ac;
    dim_t     br;
    dim_t     bc;
    elem_t    value;
    logic     typed;
    product_t want;
  } step_row_t;

  localparam int NUM_DIRECTED = 25;
  localparam step_row_t DIRECTED [NUM_DIRECTED] = '{
    // reset sizes 1x1, extremes of the element range
    '{1'b0, 4'd1, 4'd1, 4'd1, 4'd1, 16'h7fff, 1'b0, '0},
    '{1'b0, 4'd1, 4'd1, 4'd1, 4'd1, 16'h7fff, 1'b1, '{35'sd1073676289, 3'd0, 3'd0, 1'b0, 1'b1}},
    '{1'b0, 4'd1, 4'd1, 4'd1, 4'd1, 16'h8000, 1'b0, '0},
    '{1'b0, 4'd1, 4'd1, 4'd1, 4'd1, 16'h8000, 1'b1, '{35'sd1073741824, 3'd0, 3'd0, 1'b0, 1'b1}},
    '{1'b0, 4'd1, 4'd1, 4'd1, 4'd1, 16'h8000, 1'b0, '0},
    '{1'b0, 4'd1, 4'd1, 4'd1, 4'd1, 16'h7fff, 1'b1, '{-35'sd1073709056, 3'd0, 3'd0, 1'b0, 1'b1}},
    // zero sizes act as one
    '{1'b1, 4'd0, 4'd0, 4'd0, 4'd0, 16'h0003, 1'b0, '0},
    '{1'b0, 4'd0, 4'd0, 4'd0, 4'd0, 16'hfffb, 1'b1, '{-35'sd15, 3'd0, 3'd0, 1'b0, 1'b1}},
    // inner dimensions differ
    '{1'b1, 4'd1, 4'd2, 4'd1, 4'd1, 16'h1234, 1'b0, '0},
    '{1'b0, 4'd1, 4'd2, 4'd1, 4'd1, 16'hffff, 1'b0, '0},
    '{1'b0, 4'd1, 4'd2, 4'd1, 4'd1, 16'h8000, 1'b1, '{35'sd0, 3'd0, 3'd0, 1'b1, 1'b1}},
    // 2x2 by 2x2
    '{1'b1, 4'd2, 4'd2, 4'd2, 4'd2, 16'h7fff, 1'b0, '0},
    '{1'b0, 4'd2, 4'd2, 4'd2, 4'd2, 16'h8000, 1'b0, '0},
    '{1'b0, 4'd2, 4'd2, 4'd2, 4'd2, 16'h0100, 1'b0, '0},
    '{1'b0, 4'd2, 4'd2, 4'd2, 4'd2, 16'hffff, 1'b0, '0},
    '{1'b0, 4'd2, 4'd2, 4'd2, 4'd2, 16'h0001, 1'b0, '0},
    '{1'b0, 4'd2, 4'd2, 4'd2, 4'd2, 16'h8000, 1'b0, '0},
    '{1'b0, 4'd2, 4'd2, 4'd2, 4'd2, 16'h7fff, 1'b0, '0},
    '{1'b0, 4'd2, 4'd2, 4'd2, 4'd2, 16'hff00, 1'b0, '0},
    // sizes shrink mid-load: counter already past the new total
    '{1'b1, 4'd2, 4'd2, 4'd2, 4'd2, 16'h0203, 1'b0, '0},
    '{1'b0, 4'd2, 4'd2, 4'd2, 4'd2, 16'h0405, 1'b0, '0},
    '{1'b0, 4'd2, 4'd2, 4'd2, 4'd2, 16'h0607, 1'b0, '0},
    '{1'b0, 4'd2, 4'd2, 4'd2, 4'd2, 16'h0809, 1'b0, '0},
    '{1'b0, 4'd2, 4'd2, 4'd2, 4'd2, 16'hfe0b, 1'b0, '0},
    '{1'b1, 4'd1, 4'd1, 4'd1, 4'd1, 16'h0c0d, 1'b0, '0}
  };

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  cfg_reg_e         cfg_idx_i;
  dim_t             cfg_data_i;

  mm_elem_if   elem_if ();
  mm_result_if res_if ();

  matrix_multiply dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .elem_i     (elem_if),
    .result_o   (res_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // product predictor state
  dim_t       dims [4];
  elem_t      a_mem [STORE_SIZE];
  elem_t      b_mem [STORE_SIZE];
  bit         a_set [STORE_SIZE];
  bit         b_set [STORE_SIZE];
  int         fill_count;
  product_t   fresh_products [$];
  product_t   expected_products [$];
  product_t   head;

  int errors;
  int elements_in;
  int results_seen;
  int runs_done;
  int size_errors;
  int reconfigs;
  int quiet_cycles;
  bit steady;
  bit hold_seen;

  function automatic int clamp_dim(dim_t v);
    if (v == '0) return 1;
    if (v > DIM_W'(MAX_DIM)) return MAX_DIM;
    return int'(v);
  endfunction

  function automatic int run_length();
    return clamp_dim(dims[CFG_A_ROWS]) * clamp_dim(dims[CFG_A_COLS]) +
           clamp_dim(dims[CFG_B_ROWS]) * clamp_dim(dims[CFG_B_COLS]);
  endfunction

  function automatic void reset_predictor();
    foreach (dims[i]) dims[i] = DIM_W'(1);
    foreach (a_set[i]) begin
      a_set[i] = 1'b0;
      b_set[i] = 1'b0;
      a_mem[i] = '0;
      b_mem[i] = '0;
    end
    fill_count = 0;
  endfunction

  function automatic void load_element(elem_t v);
    int ar, ac, br, bc, na, nb;
    longint sum;
    product_t p;
    ar = clamp_dim(dims[CFG_A_ROWS]);
    ac = clamp_dim(dims[CFG_A_COLS]);
    br = clamp_dim(dims[CFG_B_ROWS]);
    bc = clamp_dim(dims[CFG_B_COLS]);
    na = ar * ac;
    nb = br * bc;
    fresh_products.delete();
    if (fill_count < na) begin
      a_mem[fill_count % STORE_SIZE] = v;
      a_set[fill_count % STORE_SIZE] = 1'b1;
    end else if (fill_count - na < STORE_SIZE) begin
      b_mem[fill_count - na] = v;
      b_set[fill_count - na] = 1'b1;
    end
    fill_count = (fill_count + 1) % 128;
    if (fill_count != 0 && fill_count < na + nb) return;
    fill_count = 0;
    if (ac != br) begin
      p = '0;
      p.err = 1'b1;
      p.last = 1'b1;
      fresh_products.push_back(p);
      return;
    end
    for (int r = 0; r < ar; r++) begin
      for (int c = 0; c < bc; c++) begin
        sum = 0;
        for (int k = 0; k < ac; k++) begin
          sum += longint'(a_mem[(r * ac + k) % STORE_SIZE]) *
                 longint'(b_mem[(k * bc + c) % STORE_SIZE]);
        end
        p.value = sum[ACC_W-1:0];
        p.row = IDX_W'(r);
        p.col = IDX_W'(c);
        p.err = 1'b0;
        p.last = (r == ar - 1) && (c == bc - 1);
        fresh_products.push_back(p);
      end
    end
  endfunction

  // a size change mid-load must not make the product read a never-written entry
  function automatic bit reconfig_safe(dim_t ar_raw, dim_t ac_raw, dim_t br_raw, dim_t bc_raw);
    bit aw [STORE_SIZE];
    bit bw [STORE_SIZE];
    int ar, ac, br, bc, na, nb, fc;
    aw = a_set;
    bw = b_set;
    ar = clamp_dim(ar_raw);
    ac = clamp_dim(ac_raw);
    br = clamp_dim(br_raw);
    bc = clamp_dim(bc_raw);
    na = ar * ac;
    nb = br * bc;
    fc = fill_count;
    do begin
      if (fc < na) aw[fc % STORE_SIZE] = 1'b1;
      else if (fc - na < STORE_SIZE) bw[fc - na] = 1'b1;
      fc = (fc + 1) % 128;
    end while (fc != 0 && fc < na + nb);
    if (ac != br) return 1'b1;
    for (int r = 0; r < ar; r++) begin
      for (int c = 0; c < bc; c++) begin
        for (int k = 0; k < ac; k++) begin
          if (!aw[(r * ac + k) % STORE_SIZE] || !bw[(k * bc + c) % STORE_SIZE]) return 1'b0;
        end
      end
    end
    return 1'b1;
  endfunction

  function automatic dim_t pick_dim();
    int roll;
    roll = $urandom_range(99);
    if (roll < 8) return '0;
    if (roll < 20) return DIM_W'($urandom_range(15, MAX_DIM + 1));
    if (roll < 35) return DIM_W'(MAX_DIM);
    return DIM_W'($urandom_range(MAX_DIM - 1, 1));
  endfunction

  function automatic dim_t same_size(dim_t v);
    if (clamp_dim(v) == 1) return DIM_W'($urandom_range(1));
    if (clamp_dim(v) == MAX_DIM && $urandom_range(1) == 1) return DIM_W'($urandom_range(15, MAX_DIM));
    return v;
  endfunction

  function automatic elem_t pick_element();
    case ($urandom_range(19))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return ELEM_W'($urandom_range(65535));
    endcase
  endfunction

  function automatic void check_field(string what, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      errors++;
    end
  endfunction

  task automatic send_element(input elem_t v, input bit typed, input product_t want);
    while (!steady && $urandom_range(99) < 19) begin
      elem_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    elem_if.valid <= 1'b1;
    elem_if.element_value <= v;
    @(posedge clk_i);
    while (!elem_if.ready) @(posedge clk_i);
    load_element(v);
    elements_in++;
    if (fresh_products.size() != 0) begin
      runs_done++;
      if (fresh_products[0].err) size_errors++;
    end
    if (typed) expected_products.push_back(want);
    else foreach (fresh_products[i]) expected_products.push_back(fresh_products[i]);
  endtask

  // stop offering, drain every product, let the block settle
  task automatic settle();
    elem_if.valid <= 1'b0;
    while (expected_products.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_dims(input dim_t ar, input dim_t ac, input dim_t br, input dim_t bc);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_A_ROWS;
    cfg_data_i <= ar;
    @(posedge clk_i);
    cfg_idx_i <= CFG_A_COLS;
    cfg_data_i <= ac;
    @(posedge clk_i);
    cfg_idx_i <= CFG_B_ROWS;
    cfg_data_i <= br;
    @(posedge clk_i);
    cfg_idx_i <= CFG_B_COLS;
    cfg_data_i <= bc;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    dims[CFG_A_ROWS] = ar;
    dims[CFG_A_COLS] = ac;
    dims[CFG_B_ROWS] = br;
    dims[CFG_B_COLS] = bc;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      results_seen++;
      if (expected_products.size() == 0) begin
        $display("%0t: unexpected product, expected none, actual value %0d row %0d col %0d",
                 $time, res_if.product_value, res_if.out_row, res_if.out_col);
        $display("%0t: unexpected product flags, err %0b last %0b", $time,
                 res_if.size_error, res_if.last);
        errors++;
      end else begin
        head = expected_products.pop_front();
        check_field("product_value", head.value, res_if.product_value);
        check_field("out_row", head.row, res_if.out_row);
        check_field("out_col", head.col, res_if.out_col);
        check_field("size_error", head.err, res_if.size_error);
        check_field("last", head.last, res_if.last);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (elem_if.valid && elem_if.ready) ||
        (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  // product receiver, with one long hold-off while the block is backed up
  initial begin
    int hold_left;
    hold_left = 0;
    res_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!hold_seen && results_seen >= 40 && elem_if.valid && !elem_if.ready &&
          expected_products.size() > 1) begin
        hold_seen = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= steady || ($urandom_range(99) >= 19);
      end
    end
  end

  initial begin
    dim_t ar, ac, br, bc;
    int split, random_items;
    bit mid, first, changed;
    errors = 0;
    elements_in = 0;
    results_seen = 0;
    runs_done = 0;
    size_errors = 0;
    reconfigs = 0;
    random_items = 0;
    steady = 1'b0;
    hold_seen = 1'b0;
    elem_if.valid <= 1'b0;
    elem_if.element_value <= '0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= CFG_A_ROWS;
    cfg_data_i <= '0;
    rst_ni <= 1'b0;
    reset_predictor();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      if (DIRECTED[i].set_dims) begin
        settle();
        write_dims(DIRECTED[i].ar, DIRECTED[i].ac, DIRECTED[i].br, DIRECTED[i].bc);
      end
      send_element(DIRECTED[i].value, DIRECTED[i].typed, DIRECTED[i].want);
    end

    first = 1'b1;
    while (random_items < RANDOM_ITEMS) begin
      if (first || $urandom_range(99) < 60) begin
        settle();
        if (first) begin
          ar = 4'd15;
          ac = 4'd15;
          br = 4'd15;
          bc = 4'd15;
        end else begin
          ar = pick_dim();
          ac = pick_dim();
          bc = pick_dim();
          br = ($urandom_range(99) < 20) ? pick_dim() : same_size(ac);
        end
        write_dims(ar, ac, br, bc);
        first = 1'b0;
      end
      mid = ($urandom_range(99) < 15);
      split = $urandom_range(run_length() - 1, 1);
      do begin
        if (mid && fill_count == split) begin
          mid = 1'b0;
          changed = 1'b0;
          repeat (4) begin
            if (!changed) begin
              if ($urandom_range(1) == 1) begin
                ar = DIM_W'($urandom_range(2));
                ac = DIM_W'($urandom_range(2));
                bc = DIM_W'($urandom_range(2));
              end else begin
                ar = pick_dim();
                ac = pick_dim();
                bc = pick_dim();
              end
              br = ($urandom_range(1) == 1) ? same_size(ac) : pick_dim();
              if (reconfig_safe(ar, ac, br, bc)) begin
                settle();
                write_dims(ar, ac, br, bc);
                reconfigs++;
                changed = 1'b1;
              end
            end
          end
        end
        send_element(pick_element(), 1'b0, '0);
        random_items++;
        steady = (random_items >= 200 && random_items < 300);
      end while (fill_count != 0);
    end

    steady = 1'b0;
    elem_if.valid <= 1'b0;
    while (expected_products.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);

    $display("%0d elements loaded, %0d products checked over %0d runs", elements_in,
             results_seen, runs_done);
    $display("%0d size errors, %0d mid-load size changes, receiver hold-off %0s", size_errors,
             reconfigs, hold_seen ? "done" : "missed");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/mm_pkg.sv
rtl/mm_if.sv
rtl/mm_store.sv
rtl/mm_mac.sv
rtl/matrix_multiply.sv
tb/sv/matrix_multiply_tb.sv
